/* src/chacha_pkg.sv */
// Shared types, constants and helpers for the ChaCha20 stream cipher unit.
// No dependencies; imported by chacha_core and chacha20_stream_cipher_unit.
package chacha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int NUM_WORDS   = BLOCK_BYTES / 4;
    localparam int WIDX_W      = $clog2(NUM_WORDS);
    localparam int DROUNDS     = 10;
    localparam int DR_W        = $clog2(DROUNDS);

    typedef logic [31:0]                t_word;
    typedef logic [NUM_WORDS-1:0][31:0] t_words;
    typedef logic [POS_W-1:0]           t_pos;

    localparam t_word SIGMA_0 = 32'h61707865;
    localparam t_word SIGMA_1 = 32'h3320646e;
    localparam t_word SIGMA_2 = 32'h79622d32;
    localparam t_word SIGMA_3 = 32'h6b206574;

    typedef enum logic [2:0] {
        CFG_KEY_01   = 3'd0,
        CFG_KEY_23   = 3'd1,
        CFG_KEY_45   = 3'd2,
        CFG_KEY_67   = 3'd3,
        CFG_NONCE_01 = 3'd4,
        CFG_NONCE_2  = 3'd5
    } t_cfg_idx;

    // Quarter-round step k uses rotate amounts 16, 12, 8, 7.
    function automatic t_word f_step_rotl(input t_word v, input logic [1:0] step);
        t_word r;
        case (step)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            2'd3:    r = {v[24:0], v[31:25]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Byte of the serialized keystream block at a given position.
    function automatic logic [7:0] f_ks_byte(input t_words w, input t_pos pos);
        t_word sel;
        sel = w[pos[POS_W-1:2]];
        return sel[{pos[1:0], 3'b000} +: 8];
    endfunction

endpackage

/* src/chacha20_stream_cipher_unit.sv */
// ChaCha20 stream cipher unit (96-bit nonce, 32-bit block counter) top level.
// Depends on chacha_pkg and chacha_core.
//
// Each input word (one byte) is XORed with the next keystream byte and sent out; encryption
// and decryption are the same. The user must write key and nonce through the configuration
// port only while the unit is idle; the unit does not enforce it. A byte flagged message_start
// restarts the block counter at zero. A byte that finds a keystream block in the buffer is
// XORed and registered for output, and the unit accepts one byte per cycle while the output
// register is empty or being taken. A byte at a 64-byte boundary, a message_start byte, or
// the first after reset waits for a new block from the single step unit in chacha_core that
// performs one add, xor and rotate per cycle (320 round steps, a load and a final add). The
// input is not ready while a block is being computed.
module chacha20_stream_cipher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_message_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import chacha_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_GEN  = 2'b10
    } t_top_state;

    logic [63:0] r_key01, r_key23, r_key45, r_key67, r_nonce01;
    logic [31:0] r_nonce2;

    t_top_state  r_state, n_state;
    logic [31:0] r_counter, n_counter;
    t_pos        r_pos, n_pos;
    logic        r_buf_valid, n_buf_valid;
    logic        r_gen_start, n_gen_start;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [7:0]  r_data, n_data;

    t_words init;
    t_words ks_words;
    logic   core_done;
    logic   in_ready;
    logic   accept;
    logic   need_block;

    always_comb begin
        init[0]  = SIGMA_0;
        init[1]  = SIGMA_1;
        init[2]  = SIGMA_2;
        init[3]  = SIGMA_3;
        init[4]  = r_key01[31:0];
        init[5]  = r_key01[63:32];
        init[6]  = r_key23[31:0];
        init[7]  = r_key23[63:32];
        init[8]  = r_key45[31:0];
        init[9]  = r_key45[63:32];
        init[10] = r_key67[31:0];
        init[11] = r_key67[63:32];
        init[12] = r_counter;
        init[13] = r_nonce01[31:0];
        init[14] = r_nonce01[63:32];
        init[15] = r_nonce2;
    end

    chacha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_gen_start),
        .i_init  (init),
        .o_done  (core_done),
        .o_words (ks_words)
    );

    assign in_ready   = (r_state == T_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && in_ready;
    assign need_block = i_message_start || (r_pos == '0) || !r_buf_valid;

    always_comb begin
        n_state     = r_state;
        n_counter   = r_counter;
        n_pos       = r_pos;
        n_buf_valid = r_buf_valid;
        n_gen_start = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_data      = r_data;
        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    if (need_block) begin
                        if (i_message_start) begin
                            n_counter = '0;
                            n_pos     = '0;
                        end
                        n_buf_valid = 1'b0;
                        n_gen_start = 1'b1;
                        n_data      = i_data_byte;
                        n_state     = T_GEN;
                    end else begin
                        n_out_byte  = i_data_byte ^ f_ks_byte(ks_words, r_pos);
                        n_out_valid = 1'b1;
                        n_pos       = r_pos + t_pos'(1);
                    end
                end
            end
            T_GEN: begin
                if (core_done) begin
                    n_counter   = r_counter + 32'd1;
                    n_buf_valid = 1'b1;
                    n_out_byte  = r_data ^ f_ks_byte(ks_words, r_pos);
                    n_out_valid = 1'b1;
                    n_pos       = r_pos + t_pos'(1);
                    n_state     = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_counter   <= '0;
            r_pos       <= '0;
            r_buf_valid <= 1'b0;
            r_gen_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_counter   <= n_counter;
            r_pos       <= n_pos;
            r_buf_valid <= n_buf_valid;
            r_gen_start <= n_gen_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_data     <= n_data;
    end

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key01   <= '0;
            r_key23   <= '0;
            r_key45   <= '0;
            r_key67   <= '0;
            r_nonce01 <= '0;
            r_nonce2  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_01:   r_key01   <= i_cfg_data;
                CFG_KEY_23:   r_key23   <= i_cfg_data;
                CFG_KEY_45:   r_key45   <= i_cfg_data;
                CFG_KEY_67:   r_key67   <= i_cfg_data;
                CFG_NONCE_01: r_nonce01 <= i_cfg_data;
                CFG_NONCE_2:  r_nonce2  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_cfg_ready = 1'b1;

endmodule

/* src/chacha_core.sv */
// ChaCha20 block function: one add/xor/rotate step unit, reused 320 times.
// Depends on chacha_pkg. Rows are rotated in place so the unit always works on column 0.
module chacha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  chacha_pkg::t_words i_init,
    output logic               o_done,
    output chacha_pkg::t_words o_words
);
    import chacha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ROUND = 3'b010,
        S_FINAL = 3'b100
    } t_core_state;

    t_core_state      r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic [2:0]       r_qr, n_qr;
    logic [DR_W-1:0]  r_dround, n_dround;
    logic             r_done, n_done;
    t_words           r_words, n_words;

    t_word      sum;
    t_word      mix;
    t_word      rot;
    t_words     upd;
    t_words     rowrot;
    logic [1:0] amt [4];

    always_comb begin
        sum = r_step[0] ? (r_words[8] + r_words[12]) : (r_words[0] + r_words[4]);
        mix = r_step[0] ? (r_words[4] ^ sum) : (r_words[12] ^ sum);
        rot = f_step_rotl(mix, r_step);
        upd = r_words;
        if (r_step[0]) begin
            upd[8] = sum;
            upd[4] = rot;
        end else begin
            upd[0]  = sum;
            upd[12] = rot;
        end
        // after each quarter-round shift rows left by one; the last column QR also
        // diagonalizes, the last diagonal QR also undoes it
        for (int r = 0; r < 4; r++) begin
            if (r_qr == 3'd3) begin
                amt[r] = 2'd1 + r[1:0];
            end else if (r_qr == 3'd7) begin
                amt[r] = 2'd1 - r[1:0];
            end else begin
                amt[r] = 2'd1;
            end
            for (int c = 0; c < 4; c++) begin
                rowrot[r*4 + c] = upd[r*4 + 32'(2'(c[1:0] + amt[r]))];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_qr     = r_qr;
        n_dround = r_dround;
        n_done   = 1'b0;
        n_words  = r_words;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_words  = i_init;
                    n_step   = '0;
                    n_qr     = '0;
                    n_dround = '0;
                    n_state  = S_ROUND;
                end
            end
            S_ROUND: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_words = rowrot;
                    n_qr    = r_qr + 3'd1;
                    if (r_qr == 3'd7) begin
                        if (r_dround == DR_W'(DROUNDS - 1)) begin
                            n_state = S_FINAL;
                        end else begin
                            n_dround = r_dround + DR_W'(1);
                        end
                    end
                end else begin
                    n_words = upd;
                end
            end
            S_FINAL: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    n_words[i] = r_words[i] + i_init[i];
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_qr     <= '0;
            r_dround <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_qr     <= n_qr;
            r_dround <= n_dround;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    assign o_done  = r_done;
    assign o_words = r_words;

endmodule

/* tb/tb_chacha20_stream_cipher_unit.sv */
// Self-checking testbench for chacha20_stream_cipher_unit: keystream XOR of a byte stream.
// Depends on chacha_pkg and the unit RTL; an in-bench ChaCha20 model runs on every byte.
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher_unit;
    import chacha_pkg::*;

    localparam int  LIMIT_CYCLES  = 4_000_000;
    localparam int  DRAIN_CYCLES  = 400;
    localparam int  PHASES        = 7;
    localparam int  PHASE_WORDS   = 262;
    localparam int  HOLD_CYCLES   = 600;
    localparam int  HOLD_AFTER    = 300;
    localparam int  SHOWN_ERRORS  = 10;
    localparam int  DIR_ROWS      = 16;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [7:0] din;
        logic       first;
        logic       fixed;
        logic [7:0] want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_message_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [63:0] i_cfg_data = 64'h0;

    // tag riding along with the current word: fixed expectation from the table
    logic        row_fixed = 1'b0;
    logic [7:0]  row_want = 8'h00;

    // model state
    logic [63:0] key_nonce [6];
    logic [31:0] blk_ctr;
    logic [5:0]  ks_pos;
    bit          ks_loaded;
    logic [7:0]  ks [64];
    logic [31:0] mix [16];

    logic [7:0]  pending_bytes [$];
    int          errors = 0;
    int          bytes_out = 0;
    int          cycles = 0;
    bit          hold_req = 1'b0;

    t_row        dir_rows [DIR_ROWS];
    t_cfg_idx    reg_ids [6];

    chacha20_stream_cipher_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_message_start (i_message_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter(input int a, input int b, input int c, input int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // Compute the next 64-byte keystream block from key, counter and nonce.
    function automatic void refill_keystream();
        logic [31:0] init [16];
        logic [31:0] v;
        init[0]  = SIGMA_0;
        init[1]  = SIGMA_1;
        init[2]  = SIGMA_2;
        init[3]  = SIGMA_3;
        init[4]  = key_nonce[CFG_KEY_01][31:0];
        init[5]  = key_nonce[CFG_KEY_01][63:32];
        init[6]  = key_nonce[CFG_KEY_23][31:0];
        init[7]  = key_nonce[CFG_KEY_23][63:32];
        init[8]  = key_nonce[CFG_KEY_45][31:0];
        init[9]  = key_nonce[CFG_KEY_45][63:32];
        init[10] = key_nonce[CFG_KEY_67][31:0];
        init[11] = key_nonce[CFG_KEY_67][63:32];
        init[12] = blk_ctr;
        init[13] = key_nonce[CFG_NONCE_01][31:0];
        init[14] = key_nonce[CFG_NONCE_01][63:32];
        init[15] = key_nonce[CFG_NONCE_2][31:0];
        for (int i = 0; i < 16; i++) mix[i] = init[i];
        for (int r = 0; r < 10; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            v = mix[i] + init[i];
            for (int k = 0; k < 4; k++) ks[4 * i + k] = v[8 * k +: 8];
        end
        blk_ctr   = blk_ctr + 32'd1;
        ks_loaded = 1'b1;
    endfunction

    function automatic logic [7:0] keystream_xor(input logic [7:0] d, input logic first);
        logic [7:0] r;
        if (first) begin
            blk_ctr   = 32'd0;
            ks_pos    = 6'd0;
            ks_loaded = 1'b0;
        end
        if (ks_pos == 6'd0 || !ks_loaded) refill_keystream();
        r      = d ^ ks[ks_pos];
        ks_pos = ks_pos + 6'd1;
        return r;
    endfunction

    // Half the time no gap, else mostly short ones, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 70);
    endfunction

    task automatic report(input logic [7:0] want, input logic [7:0] got, input bit orphan);
        errors++;
        if (errors <= SHOWN_ERRORS) begin
            if (orphan)
                $display("unexpected out_byte %02h with nothing pending", got);
            else
                $display("out_byte mismatch: expected %02h got %02h", want, got);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_byte(input logic [7:0] d, input logic first, input logic fixed,
                             input logic [7:0] want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= d;
        i_message_start <= first;
        row_fixed       <= fixed;
        row_want        <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input int ph);
        for (int i = 0; i < 6; i++) begin
            case (ph)
                0:       write_reg(reg_ids[i], {64{1'b1}});
                1:       write_reg(reg_ids[i], 64'h0);
                default: if ($urandom_range(0, 3) != 0) write_reg(reg_ids[i], {$urandom, $urandom});
            endcase
        end
        // spare indexes must not disturb the key or nonce
        if (ph == 0) write_reg(CFG_SPARE_6, {$urandom, $urandom});
        if (ph != 1) write_reg(CFG_SPARE_7, {$urandom, $urandom});
    endtask

    // Mostly whole messages led by a start flag; some loose words with random flags.
    task automatic random_words(input int quota);
        int sent;
        int len;
        bit loose;
        sent = 0;
        while (sent < quota) begin
            loose = ($urandom_range(0, 7) == 0);
            if (loose)
                len = $urandom_range(1, 5);
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(100, 200);
            else
                len = $urandom_range(1, 100);
            if (len > quota - sent) len = quota - sent;
            for (int j = 0; j < len; j++) begin
                push_byte(8'($urandom_range(0, 255)),
                          loose ? 1'($urandom_range(0, 1)) : (j == 0), 1'b0, 8'h00);
            end
            sent += len;
        end
    endtask

    // input side acceptance: run the model on every word taken
    always @(posedge i_clk) begin
        logic [7:0] b;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            b = keystream_xor(i_data_byte, i_message_start);
            pending_bytes = {pending_bytes, (row_fixed ? row_want : b)};
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_01, CFG_KEY_23, CFG_KEY_45, CFG_KEY_67, CFG_NONCE_01:
                    key_nonce[i_cfg_index] = i_cfg_data;
                CFG_NONCE_2:
                    key_nonce[CFG_NONCE_2] = {32'h0, i_cfg_data[31:0]};
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_out++;
            if (pending_bytes.size() == 0) begin
                report(8'h00, o_out_byte, 1'b1);
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want) report(want, o_out_byte, 1'b0);
            end
        end
    end

    // receiver: bursts of ready, random stalls, plus the long hold-off when requested
    initial begin
        int ready_left;
        int stall_left;
        ready_left = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (ready_left > 0) begin
                    ready_left--;
                end else if ($urandom_range(0, 9) == 0) begin
                    ready_left = $urandom_range(200, 500);
                end else begin
                    ready_left = $urandom_range(0, 30);
                    stall_left = idle_len();
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering words
    initial begin
        wait (bytes_out >= HOLD_AFTER);
        @(posedge i_clk);
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_req = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 6; i++) key_nonce[i] = 64'h0;
        blk_ctr   = 32'd0;
        ks_pos    = 6'd0;
        ks_loaded = 1'b0;
        reg_ids   = '{CFG_KEY_01, CFG_KEY_23, CFG_KEY_45, CFG_KEY_67, CFG_NONCE_01, CFG_NONCE_2};
        // zero key and nonce: block 0 keystream starts 76 b8 e0 ad
        dir_rows = '{
            '{8'h00, 1'b0, 1'b1, 8'h76},   // first word after reset, no start flag
            '{8'hFF, 1'b0, 1'b1, 8'h47},
            '{8'h00, 1'b0, 1'b1, 8'he0},
            '{8'h00, 1'b0, 1'b1, 8'had},
            '{8'h00, 1'b1, 1'b1, 8'h76},   // restart mid-block
            '{8'hFF, 1'b1, 1'b1, 8'h89},   // back-to-back starts
            '{8'hFF, 1'b0, 1'b1, 8'h47},
            '{8'h01, 1'b0, 1'b0, 8'h00},
            '{8'h80, 1'b0, 1'b0, 8'h00},
            '{8'h55, 1'b0, 1'b0, 8'h00},
            '{8'hAA, 1'b0, 1'b0, 8'h00},
            '{8'h7F, 1'b0, 1'b0, 8'h00},
            '{8'hFE, 1'b0, 1'b0, 8'h00},
            '{8'h00, 1'b1, 1'b1, 8'h76},
            '{8'h12, 1'b0, 1'b0, 8'h00},
            '{8'h34, 1'b0, 1'b0, 8'h00}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_byte(dir_rows[i].din, dir_rows[i].first, dir_rows[i].fixed, dir_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            stop_input();
            wait_idle();
            configure(ph);
            random_words(PHASE_WORDS);
        end

        stop_input();
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending_bytes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
src/chacha_pkg.sv
src/chacha_core.sv
src/chacha20_stream_cipher_unit.sv
tb/tb_chacha20_stream_cipher_unit.sv
